/* sv/lsep_pkg.sv */
// Package for the LED strip effect pattern core.
// Holds the mode, command and register codes, sizes and the rainbow palette.
// No dependencies.
package lsep_pkg;

  localparam int unsigned MAX_WIDTH     = 256;
  localparam int unsigned MAX_POSITIONS = 10;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned X_W     = 8;
  localparam int unsigned WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_POSITIONS + 1);
  // signed position: covers minus (MAX_POSITIONS-1) up to MAX_WIDTH
  localparam int unsigned POS_W   = WIDTH_W + 1;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef logic [COLOR_W-1:0]      color_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_FLASH     = 3'd1,
    MODE_ALTERNATE = 3'd2,
    MODE_RUNNING   = 3'd3,
    MODE_RAINBOW   = 3'd4,
    MODE_RANDOM    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_EFFECT_MODE    = 3'd0,
    REG_COLOR_ON       = 3'd1,
    REG_COLOR_OFF      = 3'd2,
    REG_STRIP_WIDTH    = 3'd3,
    REG_POSITION_COUNT = 3'd4
  } reg_e;

  localparam logic [WIDTH_W-1:0] STRIP_WIDTH_RST    = WIDTH_W'(8);
  localparam logic [CNT_W-1:0]   POSITION_COUNT_RST = CNT_W'(1);

  localparam color_t PALETTE [MAX_POSITIONS] = '{
    24'h00FF00, 24'hFFFF00, 24'hFFA500, 24'hFF0000, 24'h800080,
    24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFFA500, 24'hFF0000
  };

endpackage

/* sv/led_strip_effect_pattern_core.sv */
// LED strip effect pattern core: pattern state, APB registers, output skid.
// Depends on lsep_pkg.
//
//  channel  | signals                                   | request moves
//  ---------+-------------------------------------------+-------------------------------
//  in       | in_valid_i / in_ready_o                   | command_i, pixel_x_i, random_bit_i
//  out      | out_valid_o / out_ready_i                 | pixel_color_o (queries only)
//  config   | psel penable pwrite paddr pwdata prdata   | one 32-bit register, 4*index
//
// One request per cycle while in_ready_o is high. A query is resolved with ten parallel
// position comparators and is registered as the result, in the skid while the output stalls.
// Advance and restart update the position registers at acceptance and give no result.
// A skid register behind the result register keeps the input open while one
// result waits; in_ready_o drops only while both hold a result.
// Reset (rst_ni low, asynchronous) loads the register defaults and sets
// position i to minus i.
module led_strip_effect_pattern_core
  import lsep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [X_W-1:0]     pixel_x_i,
  input  logic               random_bit_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] pixel_color_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [2:0]         mode_q;
  color_t             color_on_q;
  color_t             color_off_q;
  logic [WIDTH_W-1:0] strip_width_q;
  logic [CNT_W-1:0]   position_count_q;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_OFF;
      color_on_q       <= '0;
      color_off_q      <= '0;
      strip_width_q    <= STRIP_WIDTH_RST;
      position_count_q <= POSITION_COUNT_RST;
    end else if (cfg_write) begin
      case (reg_e'(cfg_index))
        REG_EFFECT_MODE:    mode_q           <= pwdata[2:0];
        REG_COLOR_ON:       color_on_q       <= pwdata[COLOR_W-1:0];
        REG_COLOR_OFF:      color_off_q      <= pwdata[COLOR_W-1:0];
        REG_STRIP_WIDTH:    strip_width_q    <= pwdata[WIDTH_W-1:0];
        REG_POSITION_COUNT: position_count_q <= pwdata[CNT_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_e'(cfg_index))
      REG_EFFECT_MODE:    prdata = DATA_W'(mode_q);
      REG_COLOR_ON:       prdata = DATA_W'(color_on_q);
      REG_COLOR_OFF:      prdata = DATA_W'(color_off_q);
      REG_STRIP_WIDTH:    prdata = DATA_W'(strip_width_q);
      REG_POSITION_COUNT: prdata = DATA_W'(position_count_q);
      default:            prdata = '0;
    endcase
  end

  // Clamp count and width to what the hardware holds.
  logic [CNT_W-1:0]   act_cnt;
  logic [WIDTH_W-1:0] eff_w;
  assign act_cnt = (position_count_q > CNT_W'(MAX_POSITIONS)) ?
                   CNT_W'(MAX_POSITIONS) : position_count_q;
  assign eff_w   = (strip_width_q > WIDTH_W'(MAX_WIDTH)) ?
                   WIDTH_W'(MAX_WIDTH) : strip_width_q;

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic in_fire, out_take, query_fire;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  color_t out_data_q, out_data_d, skid_data_q, skid_data_d;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_take   = out_valid_q & out_ready_i;
  assign query_fire = in_fire & (cmd_e'(command_i) == CMD_QUERY);

  // ---------------------------------------------------------------
  // Pixel query: ten parallel comparators, lowest index wins
  // ---------------------------------------------------------------
  pos_t   pos_q [MAX_POSITIONS];
  pos_t   pos_d [MAX_POSITIONS];
  pos_t   x_pos;
  logic   hit;
  color_t hit_color;
  color_t query_color;

  assign x_pos = {{(POS_W - X_W){1'b0}}, pixel_x_i};

  always_comb begin
    hit       = 1'b0;
    hit_color = color_off_q;
    // walk down so the lowest matching index is the last to land
    for (int i = MAX_POSITIONS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < act_cnt) && (pos_q[i] == x_pos)) begin
        hit       = 1'b1;
        hit_color = PALETTE[i];
      end
    end
  end

  always_comb begin
    query_color = color_off_q;
    case (mode_e'(mode_q))
      MODE_OFF:       query_color = color_off_q;
      MODE_FLASH:     query_color = pos_q[0][0] ? color_off_q : color_on_q;
      MODE_ALTERNATE: query_color = (pos_q[0][0] ^ pixel_x_i[0]) ? color_off_q : color_on_q;
      MODE_RUNNING:   query_color = hit ? color_on_q : color_off_q;
      MODE_RAINBOW:   query_color = hit_color;
      MODE_RANDOM:    query_color = random_bit_i ? color_on_q : color_off_q;
      default:        query_color = color_off_q;
    endcase
  end

  // ---------------------------------------------------------------
  // Position update on advance and restart
  // ---------------------------------------------------------------
  pos_t width_pos;
  pos_t pos_inc [MAX_POSITIONS];

  assign width_pos = {1'b0, eff_w};

  always_comb begin
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      pos_inc[i] = pos_q[i] + pos_t'(1);
      pos_d[i]   = pos_q[i];
    end
    if (in_fire) begin
      case (cmd_e'(command_i))
        CMD_ADVANCE: begin
          case (mode_e'(mode_q))
            MODE_FLASH, MODE_ALTERNATE: begin
              // position 0 toggles between 0 and 1
              pos_d[0] = (pos_inc[0] >= pos_t'(2)) ? '0 : pos_inc[0];
            end
            MODE_RUNNING, MODE_RAINBOW: begin
              for (int i = 0; i < MAX_POSITIONS; i++) begin
                if (CNT_W'(i) < act_cnt) begin
                  pos_d[i] = (pos_inc[i] >= width_pos) ? '0 : pos_inc[i];
                end
              end
            end
            default: ;  // other modes hold the positions
          endcase
        end
        CMD_RESTART: begin
          for (int i = 0; i < MAX_POSITIONS; i++) begin
            if (CNT_W'(i) < act_cnt) begin
              pos_d[i] = -pos_t'(i);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        pos_q[i] <= -pos_t'(i);
      end
    end else begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        pos_q[i] <= pos_d[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Result register and skid
  // ---------------------------------------------------------------
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // input is closed; drain the skid into the result register
      if (out_take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (query_fire) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_data_d  = query_color;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = query_color;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = out_data_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the result register is empty");

  a_query_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire |=> out_valid_q)
    else $error("accepted query left no result");

  a_no_result_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !query_fire && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared without a query");

  a_flash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_e'(command_i) == CMD_ADVANCE) &&
     ((mode_e'(mode_q) == MODE_FLASH) || (mode_e'(mode_q) == MODE_ALTERNATE)))
    |=> ((pos_q[0] == pos_t'(0)) || (pos_q[0] == pos_t'(1))))
    else $error("flash step left its two-value range");

endmodule
